[src/fba_pkg.sv]
// fba_pkg: shared types, codes and constants of the fibonacci buddy allocator
// used by fba_csr, fba_engine and fibonacci_buddy_allocator_top
`default_nettype none
package fba_pkg;

   localparam int LEVEL_W = 5;
   localparam int ENTRY_W = LEVEL_W + 2;
   localparam int START_IDX = LEVEL_W + 1;
   localparam int FREE_IDX = LEVEL_W;

   localparam logic [7:0] HEADER_RESET = 8'd40;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_ZERO = 3'd1;
   localparam logic [2:0] ST_LARGE = 3'd2;
   localparam logic [2:0] ST_NOBLOCK = 3'd3;
   localparam logic [2:0] ST_BADFREE = 3'd4;

   localparam logic CSR_HEADER_SIZE = 1'b0;

   typedef struct packed {
      logic [2:0] status;
      logic [10:0] result_address;
      logic [10:0] result_size;
      logic [3:0] result_level;
      logic [10:0] allocated_units;
   } fba_rsp_type;

   // fibonacci size of a level, elaboration use only
   function automatic int unsigned fib_val(input int lvl);
      int unsigned f0;
      int unsigned f1;
      int unsigned f2;
      f0 = 1;
      f1 = 2;
      for (int i = 0; i < lvl; i++) begin
         f2 = f0 + f1;
         f0 = f1;
         f1 = f2;
      end
      return f0;
   endfunction

endpackage
`default_nettype wire

[src/fba_ram.sv]
// fba_ram: generic simple dual-port ram with registered read data
// no dependencies
`default_nettype none
module fba_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 2048
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[src/fba_csr.sv]
// fba_csr: apb-style register port holding header_size
// depends on fba_pkg
`default_nettype none
module fba_csr
   import fba_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [2:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output logic [7:0] header_size
);

   logic [7:0] header_ff;
   logic [7:0] header_in;

   always_comb begin
      header_in = header_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_HEADER_SIZE) begin
         header_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else begin
         header_ff <= header_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_HEADER_SIZE) ? {24'd0, header_ff} : 32'd0;
   assign header_size = header_ff;

endmodule
`default_nettype wire

[src/fba_engine.sv]
// fba_engine: allocate/free sequencer around the block map ram
// depends on fba_pkg and fba_ram
`default_nettype none
module fba_engine
   import fba_pkg::*;
#(
   parameter int LEVELS = 16,
   parameter int ADDR_WIDTH = 11
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [7:0] header_size,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_command,
   input wire logic [10:0] req_request_size,
   input wire logic [10:0] req_block_address,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output fba_rsp_type rsp_word
);

   localparam int AW = ADDR_WIDTH;
   localparam int DEPTH = 1 << AW;
   localparam int IW = $clog2(LEVELS);
   localparam int FIB_TOP = int'(fib_val(LEVELS - 1));
   localparam int FW = $clog2(FIB_TOP + 1);
   localparam int HEAP = (FIB_TOP < DEPTH) ? FIB_TOP : DEPTH;
   localparam int CW = (FW > 12) ? FW : 12;
   localparam int MW = ((AW > FW) ? AW : FW) + 1;
   localparam int XW = (AW + 1 > 11) ? AW + 1 : 11;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SCAN = 4'd2;
   localparam logic [3:0] S_SPLIT = 4'd3;
   localparam logic [3:0] S_FCHK = 4'd4;
   localparam logic [3:0] S_LOC = 4'd5;
   localparam logic [3:0] S_SCHK = 4'd6;
   localparam logic [3:0] S_MRG = 4'd7;
   localparam logic [3:0] S_OUT = 4'd8;

   logic [FW-1:0] fib_tab [LEVELS];

   for (genvar g = 0; g < LEVELS; g++) begin : g_fib
      assign fib_tab[g] = FW'(fib_val(g));
   end

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   fba_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_map (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [3:0] state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW:0] scan_ff, scan_in;
   logic rdv_ff, rdv_in;
   logic [AW-1:0] rdq_ff, rdq_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic lg_ff, lg_in;
   logic [AW-1:0] la_ff, la_in;
   logic [IW-1:0] ll_ff, ll_in;
   logic [AW-1:0] base_ff, base_in;
   logic [IW-1:0] lev_ff, lev_in;
   logic [AW-1:0] fa_ff, fa_in;
   logic [MW-1:0] cur_a_ff, cur_a_in;
   logic [IW-1:0] cur_k_ff, cur_k_in;
   logic [MW-1:0] lb_ff, lb_in;
   logic [IW-1:0] lk_ff, lk_in;
   logic [MW-1:0] sa_ff, sa_in;
   logic [IW-1:0] sk_ff, sk_in;
   logic [MW-1:0] pa_ff, pa_in;
   logic [IW-1:0] pk_ff, pk_in;
   logic [FW-1:0] total_ff, total_in;
   fba_rsp_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   fba_rsp_type rsp_ff, rsp_in;

   logic [11:0] req_total;
   logic [IW-1:0] tgt;
   logic [LEVEL_W-1:0] e_lev;
   logic [MW-1:0] mid;
   logic [AW+FW-1:0] right;

   always_comb begin
      req_total = 12'(req_request_size) + 12'(header_size);
      tgt = IW'(LEVELS - 1);
      for (int i = LEVELS - 2; i >= 0; i--) begin
         if (CW'(fib_tab[i]) >= CW'(req_total)) begin
            tgt = IW'(i);
         end
      end
      if (tgt == '0) begin
         tgt = IW'(1);
      end
   end

   assign e_lev = rd_data[LEVEL_W-1:0];
   assign mid = lb_ff + MW'(fib_tab[lk_ff - IW'(1)]);
   assign right = (AW + FW)'(base_ff) + (AW + FW)'(fib_tab[lev_ff - IW'(1)]);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      scan_in = scan_ff;
      rdv_in = 1'b0;
      rdq_in = rdq_ff;
      tgt_in = tgt_ff;
      lg_in = lg_ff;
      la_in = la_ff;
      ll_in = ll_ff;
      base_in = base_ff;
      lev_in = lev_ff;
      fa_in = fa_ff;
      cur_a_in = cur_a_ff;
      cur_k_in = cur_k_ff;
      lb_in = lb_ff;
      lk_in = lk_ff;
      sa_in = sa_ff;
      sk_in = sk_ff;
      pa_in = pa_ff;
      pk_in = pk_ff;
      total_in = total_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_en = 1'b0;
      rd_addr = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == '0) ? {2'b11, LEVEL_W'(LEVELS - 1)} : '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            res_in = '0;
            if (req_valid) begin
               if (req_command == CMD_ALLOC) begin
                  if (req_request_size == '0) begin
                     res_in.status = ST_ZERO;
                     state_in = S_OUT;
                  end else if (CW'(req_total) > CW'(fib_tab[LEVELS-1])) begin
                     res_in.status = ST_LARGE;
                     state_in = S_OUT;
                  end else begin
                     tgt_in = tgt;
                     scan_in = '0;
                     lg_in = 1'b0;
                     state_in = S_SCAN;
                  end
               end else begin
                  if (XW'(req_block_address) >= XW'(HEAP)) begin
                     res_in.status = ST_BADFREE;
                     state_in = S_OUT;
                  end else begin
                     fa_in = AW'(XW'(req_block_address));
                     rd_en = 1'b1;
                     rd_addr = AW'(XW'(req_block_address));
                     state_in = S_FCHK;
                  end
               end
            end
         end
         S_SCAN: begin
            if (scan_ff != (AW + 1)'(HEAP)) begin
               rd_en = 1'b1;
               rd_addr = scan_ff[AW-1:0];
               rdq_in = scan_ff[AW-1:0];
               rdv_in = 1'b1;
               scan_in = scan_ff + (AW + 1)'(1);
            end
            if (rdv_ff && rd_data[START_IDX] && rd_data[FREE_IDX]
                  && e_lev == LEVEL_W'(tgt_ff)) begin
               base_in = rdq_ff;
               lev_in = tgt_ff;
               rdv_in = 1'b0;
               state_in = S_SPLIT;
            end else begin
               if (rdv_ff && rd_data[START_IDX] && rd_data[FREE_IDX]
                     && e_lev > LEVEL_W'(tgt_ff) && (!lg_ff || e_lev < LEVEL_W'(ll_ff))) begin
                  lg_in = 1'b1;
                  la_in = rdq_ff;
                  ll_in = IW'(e_lev);
               end
               if (!rdv_ff && scan_ff == (AW + 1)'(HEAP)) begin
                  if (lg_ff) begin
                     base_in = la_ff;
                     lev_in = ll_ff;
                     state_in = S_SPLIT;
                  end else begin
                     res_in.status = ST_NOBLOCK;
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_SPLIT: begin
            wr_en = 1'b1;
            if (lev_ff > tgt_ff) begin
               wr_addr = right[AW-1:0];
               wr_data = {2'b11, LEVEL_W'(lev_ff - IW'(2))};
               lev_in = lev_ff - IW'(1);
            end else begin
               wr_addr = base_ff;
               wr_data = {2'b10, LEVEL_W'(lev_ff)};
               total_in = total_ff + fib_tab[lev_ff];
               res_in.status = ST_OK;
               res_in.result_address = 11'(base_ff);
               res_in.result_size = 11'(fib_tab[lev_ff]);
               res_in.result_level = 4'(lev_ff);
               state_in = S_OUT;
            end
         end
         S_FCHK: begin
            if (!rd_data[START_IDX] || rd_data[FREE_IDX] || e_lev >= LEVEL_W'(LEVELS)) begin
               res_in.status = ST_BADFREE;
               state_in = S_OUT;
            end else begin
               wr_en = 1'b1;
               wr_addr = fa_ff;
               wr_data = rd_data | (ENTRY_W'(1) << FREE_IDX);
               total_in = total_ff - fib_tab[IW'(e_lev)];
               res_in.status = ST_OK;
               res_in.result_address = 11'(fa_ff);
               res_in.result_size = 11'(fib_tab[IW'(e_lev)]);
               res_in.result_level = 4'(e_lev);
               cur_a_in = MW'(fa_ff);
               cur_k_in = IW'(e_lev);
               lb_in = '0;
               lk_in = IW'(LEVELS - 1);
               state_in = S_LOC;
            end
         end
         S_LOC: begin
            if (lk_ff == IW'(LEVELS - 1) && cur_a_ff == '0 && cur_k_ff == IW'(LEVELS - 1)) begin
               state_in = S_OUT;
            end else if (lk_ff < IW'(2)) begin
               state_in = S_OUT;
            end else if (cur_a_ff < mid) begin
               if (cur_a_ff == lb_ff && cur_k_ff == lk_ff - IW'(1)) begin
                  sa_in = mid;
                  sk_in = lk_ff - IW'(2);
                  pa_in = lb_ff;
                  pk_in = lk_ff;
                  rd_en = 1'b1;
                  rd_addr = mid[AW-1:0];
                  state_in = S_SCHK;
               end else begin
                  lk_in = lk_ff - IW'(1);
               end
            end else begin
               if (cur_a_ff == mid && cur_k_ff == lk_ff - IW'(2)) begin
                  sa_in = lb_ff;
                  sk_in = lk_ff - IW'(1);
                  pa_in = lb_ff;
                  pk_in = lk_ff;
                  rd_en = 1'b1;
                  rd_addr = lb_ff[AW-1:0];
                  state_in = S_SCHK;
               end else begin
                  lb_in = mid;
                  lk_in = lk_ff - IW'(2);
               end
            end
         end
         S_SCHK: begin
            if (rd_data[START_IDX] && rd_data[FREE_IDX] && e_lev == LEVEL_W'(sk_ff)) begin
               wr_en = 1'b1;
               wr_addr = (pa_ff == cur_a_ff) ? sa_ff[AW-1:0] : cur_a_ff[AW-1:0];
               wr_data = '0;
               state_in = S_MRG;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MRG: begin
            wr_en = 1'b1;
            wr_addr = pa_ff[AW-1:0];
            wr_data = {2'b11, LEVEL_W'(pk_ff)};
            cur_a_in = pa_ff;
            cur_k_in = pk_ff;
            lb_in = '0;
            lk_in = IW'(LEVELS - 1);
            state_in = S_LOC;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_in.allocated_units = 11'(total_ff);
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rdv_ff <= 1'b0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rdv_ff <= rdv_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      rdq_ff <= rdq_in;
      tgt_ff <= tgt_in;
      lg_ff <= lg_in;
      la_ff <= la_in;
      ll_ff <= ll_in;
      base_ff <= base_in;
      lev_ff <= lev_in;
      fa_ff <= fa_in;
      cur_a_ff <= cur_a_in;
      cur_k_ff <= cur_k_in;
      lb_ff <= lb_in;
      lk_ff <= lk_in;
      sa_ff <= sa_in;
      sk_ff <= sk_in;
      pa_ff <= pa_in;
      pk_ff <= pk_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule
`default_nettype wire

[src/fibonacci_buddy_allocator_top.sv]
// fibonacci buddy allocator, top level
// holds the register port and the allocate/free engine
// depends on fba_pkg, fba_csr, fba_engine and fba_ram
//
// req_ carries one allocate or free word, rsp_ returns one result word for each.
// csr_ holds header_size at byte address 0; the user must write it only while the
// block is idle, as the block itself does not enforce this. after reset the block
// map ram is swept, one entry a cycle, over all 2**ADDR_WIDTH entries; req_tready
// stays low during the sweep. one word is in work at a time. allocate scans the
// block map (one read a cycle on its single read port; an exact fit stops the scan
// early), writes the right half of each split, makes the final write and loads
// the result. free reads the entry, marks it free and walks the tree; a merge
// clears one entry, writes the merged block and walks again. zero-size, oversize
// and out-of-range free words go straight to the result load, other bad frees
// after the entry read. a new word can be accepted once the result is loaded.
// the result sits in an output register; while rsp_tready is low the next word
// can be accepted and worked on, and its result waits until the register frees.
`default_nettype none
module fibonacci_buddy_allocator_top
   import fba_pkg::*;
#(
   parameter int LEVELS = 16,
   parameter int ADDR_WIDTH = 11
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [23:0] req_tdata,  // request_size, block_address, 2'b0
   input wire logic [0:0] req_tuser,   // command
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // status, result_address, result_size, result_level, allocated_units
   output logic [39:0] rsp_tdata,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [2:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [7:0] header_size;
   fba_rsp_type rsp_word;

   fba_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .header_size(header_size)
   );

   fba_engine #(
      .LEVELS(LEVELS),
      .ADDR_WIDTH(ADDR_WIDTH)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .header_size(header_size),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_command(req_tuser[0]),
      .req_request_size(req_tdata[10:0]),
      .req_block_address(req_tdata[21:11]),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_word(rsp_word)
   );

   assign rsp_tdata = {rsp_word.allocated_units, rsp_word.result_level,
                       rsp_word.result_size, rsp_word.result_address, rsp_word.status};

endmodule
`default_nettype wire
